@@ sv/ggba_pkg.sv @@
// ----------------------------------------------------------------------------
// ggba_pkg
// Shared constants, command/status types and divider sizing for the geo grid
// bin accumulator.
// ----------------------------------------------------------------------------
package ggba_pkg;

    // Grid geometry in 1/64 degree units
    localparam logic signed [15:0] LAT_HALF   = 16'sd5760;
    localparam logic signed [15:0] LAT_SPAN_S = 16'sd11520;
    localparam logic signed [17:0] LON_SPAN_S = 18'sd23040;

    // Spans are 45 * 2^8 and 45 * 2^9: shift out the power of two, then
    // divide by 45 as (y * RECIP_45) >> RECIP_SH, exact for y below 74898
    localparam logic [14:0] RECIP_45 = 15'd11651;
    localparam int          RECIP_SH = 19;

    localparam logic [15:0] HIT_MAX = 16'hFFFF;

    // Average divider: 32-bit dividend, 17-bit divisor, 15 quotient bits
    localparam int DIV_NW = 32;
    localparam int DIV_DW = 17;
    localparam int DIV_QW = 15;

    typedef enum logic [2:0] {
        MS_ROW,
        MS_COL,
        MS_IDX,
        MS_LIM,
        MS_AVG
    } t_mul_sel;

    typedef enum logic [1:0] {
        RS_ADD_OOR,
        RS_RD_OOR,
        RS_BIN,
        RS_UPD
    } t_res_sel;

    typedef struct packed {
        logic     load;
        logic     clr_step;
        logic     mul_go;
        t_mul_sel mul_sel;
        logic     div_go;
        logic     cap_row;
        logic     cap_col;
        logic     idx_add;
        logic     ram_rd;
        logic     cap_bin;
        logic     sum_go;
        logic     upd;
        logic     res_load;
        t_res_sel res_sel;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_read;
        logic add_oor;
        logic rd_oor;
        logic is_cap;
        logic div_done;
    } t_status;

endpackage

@@ sv/ggba_ram.sv @@
// ----------------------------------------------------------------------------
// ggba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ggba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

@@ sv/ggba_div.sv @@
// ----------------------------------------------------------------------------
// ggba_div
// Restoring divider, one quotient bit per cycle, for dividends whose
// quotient is known to fit in DIV_QW bits.
// ----------------------------------------------------------------------------
module ggba_div
    import ggba_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic [DIV_QW-1:0] o_quo,
    output logic              o_done
);

    localparam int CNT_W = $clog2(DIV_QW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_QW-1:0] r_q;

    logic [DIV_DW:0]   trial;
    logic              fits;
    logic [DIV_DW-1:0] n_rem;
    logic [DIV_QW-1:0] n_q;

    always_comb begin
        trial = {r_rem, r_q[DIV_QW-1]};
        fits  = trial >= {1'b0, r_den};
        n_rem = fits ? DIV_DW'(trial - {1'b0, r_den}) : DIV_DW'(trial);
        n_q   = {r_q[DIV_QW-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // High dividend bits seed the remainder; they stay below the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[DIV_NW-1:DIV_QW];
            r_q   <= i_num[DIV_QW-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_quo  = r_q;
    assign o_done = r_done;

endmodule

@@ sv/ggba_dpath.sv @@
// ----------------------------------------------------------------------------
// ggba_dpath
// Datapath: configuration registers, shared multiplier, reciprocal row and
// column scaling, average divider, bin store and result register.
// ----------------------------------------------------------------------------
module ggba_dpath
    import ggba_pkg::*;
#(
    parameter int MAX_LAT_BINS = 128,
    parameter int MAX_LON_BINS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_op,
    input  logic [13:0] i_lat,
    input  logic [14:0] i_lon,
    input  logic [14:0] i_energy,
    input  logic [14:0] i_read_index,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output logic [14:0] o_bin_index,
    output logic [14:0] o_bin_amplitude,
    output logic [15:0] o_bin_hits,
    output logic        o_bin_filled,
    output logic        o_out_of_range
);

    localparam int DEPTH = MAX_LAT_BINS * MAX_LON_BINS;
    localparam int IW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int RRW   = MAX_LAT_BINS > 1 ? $clog2(MAX_LAT_BINS) : 1;
    localparam int CRW   = MAX_LON_BINS > 1 ? $clog2(MAX_LON_BINS) : 1;
    localparam int MW    = 33;

    localparam logic [2:0] CFG_LAT_BINS  = 3'd0;
    localparam logic [2:0] CFG_LON_BINS  = 3'd1;
    localparam logic [2:0] CFG_LAT_SHIFT = 3'd2;
    localparam logic [2:0] CFG_LON_SHIFT = 3'd3;
    localparam logic [2:0] CFG_NOISE_THR = 3'd4;

    // Configuration
    logic [7:0]         r_lat_bins;
    logic [8:0]         r_lon_bins;
    logic signed [13:0] r_lat_shift;
    logic signed [15:0] r_lon_shift;
    logic signed [14:0] r_thr;

    // Item registers
    logic               r_op;
    logic signed [15:0] r_n;
    logic signed [17:0] r_m;
    logic signed [14:0] r_e;
    logic [14:0]        r_ridx;
    logic [31:0]        r_prod;
    logic               r_neg;
    logic [RRW-1:0]     r_row;
    logic [CRW-1:0]     r_col;
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      r_clr;
    logic signed [15:0] r_amp;
    logic [15:0]        r_hits;
    logic               r_valid;

    // Result register
    logic [14:0] r_res_idx;
    logic [14:0] r_res_amp;
    logic [15:0] r_res_hits;
    logic        r_res_filled;
    logic        r_res_oor;

    logic [15:0]        rows;
    logic [15:0]        cols;
    logic signed [13:0] lat_s;
    logic [15:0]        mul_a;
    logic [15:0]        mul_b;
    logic [39:0]        row_rec;
    logic [39:0]        col_rec;
    logic signed [15:0] amp_cur;
    logic [15:0]        amp_abs;
    logic signed [33:0] sum_sp;
    logic signed [33:0] sum_v;
    logic [DIV_DW-1:0]  den;
    logic [DIV_QW-1:0]  quo;
    logic               div_done;
    logic signed [15:0] e16;
    logic signed [15:0] ne16;
    logic signed [15:0] qv;
    logic signed [15:0] q_avg;
    logic [15:0]        hits_inc;
    logic signed [15:0] upd_amp;
    logic [15:0]        upd_hits;
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [MW-1:0]      ram_wdata;
    logic [MW-1:0]      ram_rdata;

    always_comb begin
        if (r_lat_bins == 8'd0) begin
            rows = 16'd1;
        end else if (16'(r_lat_bins) > 16'(MAX_LAT_BINS)) begin
            rows = 16'(MAX_LAT_BINS);
        end else begin
            rows = 16'(r_lat_bins);
        end
        if (r_lon_bins == 9'd0) begin
            cols = 16'd1;
        end else if (16'(r_lon_bins) > 16'(MAX_LON_BINS)) begin
            cols = 16'(MAX_LON_BINS);
        end else begin
            cols = 16'(r_lon_bins);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_bins  <= 8'd128;
            r_lon_bins  <= 9'd256;
            r_lat_shift <= '0;
            r_lon_shift <= '0;
            r_thr       <= -15'sd26;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LAT_BINS:  r_lat_bins  <= i_cfg_data[7:0];
                CFG_LON_BINS:  r_lon_bins  <= i_cfg_data[8:0];
                CFG_LAT_SHIFT: r_lat_shift <= i_cfg_data[13:0];
                CFG_LON_SHIFT: r_lon_shift <= i_cfg_data;
                CFG_NOISE_THR: r_thr       <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Clear sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    assign lat_s = i_lat;

    always_comb begin
        amp_cur = r_valid ? r_amp : 16'sd0;
        amp_abs = amp_cur[15] ? 16'(-amp_cur) : 16'(amp_cur);
        case (i_cmd.mul_sel)
            MS_ROW:  begin mul_a = 16'(r_n);   mul_b = rows;    end
            MS_COL:  begin mul_a = 16'(r_m);   mul_b = cols;    end
            MS_IDX:  begin mul_a = 16'(r_row); mul_b = cols;    end
            MS_LIM:  begin mul_a = rows;       mul_b = cols;    end
            default: begin mul_a = r_hits;     mul_b = amp_abs; end
        endcase
        // floor(prod / 11520) and floor(prod / 23040)
        row_rec = 40'(r_prod[31:8]) * 40'(RECIP_45);
        col_rec = 40'(r_prod[31:9]) * 40'(RECIP_45);
        den     = 17'(r_hits) + 17'd1;
        sum_sp = $signed({2'b00, r_prod});
        if (amp_cur[15]) begin
            sum_sp = -sum_sp;
        end
        sum_v = sum_sp + 34'(r_e);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_n    <= LAT_HALF - 16'(lat_s) - 16'(r_lat_shift);
            r_m    <= $signed({3'b000, i_lon}) + 18'(r_lon_shift);
            r_e    <= i_energy;
            r_ridx <= i_read_index;
            r_idx  <= IW'(i_read_index);
        end
        if (i_cmd.mul_go) begin
            r_prod <= mul_a * mul_b;
        end else if (i_cmd.sum_go) begin
            r_neg  <= sum_v[33];
            r_prod <= sum_v[33] ? 32'(-sum_v) : 32'(sum_v);
        end
        if (i_cmd.cap_row) begin
            r_row <= RRW'(row_rec >> RECIP_SH);
        end
        if (i_cmd.cap_col) begin
            r_col <= CRW'(col_rec >> RECIP_SH);
        end
        if (i_cmd.idx_add) begin
            r_idx <= IW'(r_prod + 32'(r_col));
        end
        if (i_cmd.cap_bin) begin
            r_valid <= ram_rdata[32];
            r_hits  <= ram_rdata[31:16];
            r_amp   <= ram_rdata[15:0];
        end
    end

    ggba_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_go),
        .i_num   (r_prod),
        .i_den   (den),
        .o_quo   (quo),
        .o_done  (div_done)
    );

    // New bin contents
    always_comb begin
        e16      = 16'(r_e);
        ne16     = -e16;
        hits_inc = (r_hits == HIT_MAX) ? r_hits : r_hits + 16'd1;
        qv       = $signed({1'b0, quo});
        q_avg    = r_neg ? -qv : qv;
        if (o_status.is_cap) begin
            if (!r_valid) begin
                upd_amp  = e16;
                upd_hits = r_hits;
            end else if (amp_cur > ne16) begin
                upd_amp  = ne16;
                upd_hits = hits_inc;
            end else if (amp_cur < e16) begin
                upd_amp  = e16;
                upd_hits = r_hits;
            end else begin
                upd_amp  = amp_cur;
                upd_hits = r_hits;
            end
        end else begin
            upd_amp  = (q_avg < e16) ? e16 : q_avg;
            upd_hits = hits_inc;
        end
    end

    assign ram_we    = i_cmd.clr_step | i_cmd.upd;
    assign ram_waddr = i_cmd.clr_step ? r_clr : r_idx;
    assign ram_wdata = i_cmd.clr_step ? '0 : {1'b1, upd_hits, upd_amp};

    ggba_ram #(
        .WIDTH (MW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.ram_rd),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            case (i_cmd.res_sel)
                RS_ADD_OOR: begin
                    r_res_idx    <= '0;
                    r_res_amp    <= '0;
                    r_res_hits   <= '0;
                    r_res_filled <= 1'b0;
                    r_res_oor    <= 1'b1;
                end
                RS_RD_OOR: begin
                    r_res_idx    <= r_ridx;
                    r_res_amp    <= '0;
                    r_res_hits   <= '0;
                    r_res_filled <= 1'b0;
                    r_res_oor    <= 1'b1;
                end
                RS_BIN: begin
                    r_res_idx    <= 15'(r_idx);
                    r_res_amp    <= r_valid ? r_amp[14:0] : 15'd0;
                    r_res_hits   <= r_hits;
                    r_res_filled <= r_valid;
                    r_res_oor    <= 1'b0;
                end
                default: begin
                    r_res_idx    <= 15'(r_idx);
                    r_res_amp    <= upd_amp[14:0];
                    r_res_hits   <= upd_hits;
                    r_res_filled <= 1'b1;
                    r_res_oor    <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_status.clr_last = r_clr == IW'(DEPTH - 1);
        o_status.is_read  = r_op;
        o_status.add_oor  = (r_n < 16'sd0) || (r_n >= LAT_SPAN_S) ||
                            (r_m < 18'sd0) || (r_m >= LON_SPAN_S);
        o_status.rd_oor   = 32'(r_ridx) >= r_prod;
        o_status.is_cap   = r_e < r_thr;
        o_status.div_done = div_done;
    end

    assign o_bin_index     = r_res_idx;
    assign o_bin_amplitude = r_res_amp;
    assign o_bin_hits      = r_res_hits;
    assign o_bin_filled    = r_res_filled;
    assign o_out_of_range  = r_res_oor;

endmodule

@@ sv/ggba_ctrl.sv @@
// ----------------------------------------------------------------------------
// ggba_ctrl
// Controller: sequences store clear, bin lookup, the averaging divider pass
// and the read-modify-write of one bin; owns the output valid.
// ----------------------------------------------------------------------------
module ggba_ctrl
    import ggba_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    input  logic    i_m_ready,
    input  t_status i_status,
    output logic    o_s_ready,
    output logic    o_m_valid,
    output t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_LIM_MUL,
        ST_LIM_CMP,
        ST_ROW_MUL,
        ST_ROW_REC,
        ST_COL_MUL,
        ST_COL_REC,
        ST_IDX_MUL,
        ST_IDX_ADD,
        ST_RD,
        ST_RD_DATA,
        ST_AVG_MUL,
        ST_AVG_SUM,
        ST_AVG_DS,
        ST_AVG_DW,
        ST_UPDATE,
        ST_RESULT
    } t_state;

    t_state   r_state;
    t_state   n_state;
    t_res_sel r_res_sel;
    t_res_sel n_res_sel;
    logic     r_m_valid;
    logic     out_free;

    assign out_free = !r_m_valid || i_m_ready;

    always_comb begin
        o_cmd     = '0;
        n_state   = r_state;
        n_res_sel = r_res_sel;
        o_cmd.res_sel = r_res_sel;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_status.is_read) begin
                    n_state = ST_LIM_MUL;
                end else if (i_status.add_oor) begin
                    n_res_sel = RS_ADD_OOR;
                    n_state   = ST_RESULT;
                end else begin
                    n_state = ST_ROW_MUL;
                end
            end
            ST_LIM_MUL: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = MS_LIM;
                n_state       = ST_LIM_CMP;
            end
            ST_LIM_CMP: begin
                if (i_status.rd_oor) begin
                    n_res_sel = RS_RD_OOR;
                    n_state   = ST_RESULT;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_ROW_MUL: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = MS_ROW;
                n_state       = ST_ROW_REC;
            end
            ST_ROW_REC: begin
                o_cmd.cap_row = 1'b1;
                n_state       = ST_COL_MUL;
            end
            ST_COL_MUL: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = MS_COL;
                n_state       = ST_COL_REC;
            end
            ST_COL_REC: begin
                o_cmd.cap_col = 1'b1;
                n_state       = ST_IDX_MUL;
            end
            ST_IDX_MUL: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = MS_IDX;
                n_state       = ST_IDX_ADD;
            end
            ST_IDX_ADD: begin
                o_cmd.idx_add = 1'b1;
                n_state       = ST_RD;
            end
            ST_RD: begin
                o_cmd.ram_rd = 1'b1;
                n_state      = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                o_cmd.cap_bin = 1'b1;
                if (i_status.is_read) begin
                    n_res_sel = RS_BIN;
                    n_state   = ST_RESULT;
                end else if (i_status.is_cap) begin
                    n_state = ST_UPDATE;
                end else begin
                    n_state = ST_AVG_MUL;
                end
            end
            ST_AVG_MUL: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = MS_AVG;
                n_state       = ST_AVG_SUM;
            end
            ST_AVG_SUM: begin
                o_cmd.sum_go = 1'b1;
                n_state      = ST_AVG_DS;
            end
            ST_AVG_DS: begin
                o_cmd.div_go = 1'b1;
                n_state      = ST_AVG_DW;
            end
            ST_AVG_DW: begin
                if (i_status.div_done) n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                // hold until the result register is free, then commit both
                if (out_free) begin
                    o_cmd.upd      = 1'b1;
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RS_UPD;
                    n_state        = ST_IDLE;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_res_sel <= RS_ADD_OOR;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_res_sel <= n_res_sel;
            if (o_cmd.res_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_s_ready = r_state == ST_IDLE;
    assign o_m_valid = r_m_valid;

endmodule

@@ sv/geo_grid_bin_accumulator_unit.sv @@
// ----------------------------------------------------------------------------
// geo_grid_bin_accumulator_unit
// Bins (latitude, longitude, energy) samples into a lat/lon grid and reads
// single bins back.
// ----------------------------------------------------------------------------
// After reset the bin store is swept clear, one entry per cycle, over all
// MAX_LAT_BINS * MAX_LON_BINS entries (32768 at the defaults); no sample is
// taken during the sweep, configuration writes are. Items are processed one
// at a time; a finished result waits in the output register while the next
// transaction is already taken. Work per item: an out-of-grid sample goes
// from the range check straight to the result; a bin read checks its index
// against rows * cols, then reads the store; a below-noise sample finds row
// and column by shared multiplier plus reciprocal scaling, then does the
// registered store read; an averaging sample adds a 15-step restoring
// divider pass over the hit count plus one. A result still waiting in the
// output register holds the final step. Rows and columns come from
// floor(offset * bins / span); a negative offset or one at or beyond the
// span is out of the grid and leaves the store untouched.
// ----------------------------------------------------------------------------
module geo_grid_bin_accumulator_unit
    import ggba_pkg::*;
#(
    parameter int MAX_LAT_BINS = 128,
    parameter int MAX_LON_BINS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // sample / read transactions
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: latitude[13:0], longitude[28:14], energy[43:29],
    //        read_index[58:44], zero[63:59]
    input  logic [63:0] i_s_tdata,
    // tuser: operation[0]
    input  logic        i_s_tuser,
    // results
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: bin_index[14:0], bin_amplitude[29:15], bin_hits[45:30],
    //        bin_filled[46], out_of_range[47]
    output logic [47:0] o_m_tdata
);

    t_cmd    cmd;
    t_status status;

    logic [14:0] bin_index;
    logic [14:0] bin_amplitude;
    logic [15:0] bin_hits;
    logic        bin_filled;
    logic        out_of_range;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    ggba_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .i_m_ready (i_m_tready),
        .i_status  (status),
        .o_s_ready (o_s_tready),
        .o_m_valid (o_m_tvalid),
        .o_cmd     (cmd)
    );

    ggba_dpath #(
        .MAX_LAT_BINS (MAX_LAT_BINS),
        .MAX_LON_BINS (MAX_LON_BINS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_op            (i_s_tuser),
        .i_lat           (i_s_tdata[13:0]),
        .i_lon           (i_s_tdata[28:14]),
        .i_energy        (i_s_tdata[43:29]),
        .i_read_index    (i_s_tdata[58:44]),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_bin_index     (bin_index),
        .o_bin_amplitude (bin_amplitude),
        .o_bin_hits      (bin_hits),
        .o_bin_filled    (bin_filled),
        .o_out_of_range  (out_of_range)
    );

    // pack result fields, index in the lowest bits
    assign o_m_tdata = {out_of_range, bin_filled, bin_hits, bin_amplitude, bin_index};

endmodule

@@ sv/ggba_chk.sv @@
// ----------------------------------------------------------------------------
// ggba_chk
// Port-level checks for the geo grid bin accumulator.
// ----------------------------------------------------------------------------
module ggba_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // out-of-grid result carries no bin contents
    a_oor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[47] |-> o_m_tdata[46:15] == 32'd0)
        else $error("out-of-range result with bin contents");

    // unfilled bin reads zero amplitude
    a_unfilled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[46] |-> o_m_tdata[29:15] == 15'd0)
        else $error("unfilled bin with nonzero amplitude");

    // reset drops results and starts the store sweep
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !o_s_tready)
        else $error("block active right after reset");

endmodule

bind geo_grid_bin_accumulator_unit ggba_chk u_ggba_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for geo_grid_bin_accumulator_unit: drives sample and
// bin-read transactions, mirrors the bin store in a local grid model, and
// compares every result field by field; stream sides idle at random but at the end.
// ----------------------------------------------------------------------------
module tb;
    import ggba_pkg::*;

    localparam int ROWS_MAX   = 128;
    localparam int COLS_MAX   = 256;
    localparam int GRID_DEPTH = ROWS_MAX * COLS_MAX;
    localparam int IDLE_LIMIT = 120000;  // covers the clearing sweep after reset
    localparam int HOLD_LEN   = 400;
    localparam int SETTLE     = 100;

    // register indexes
    localparam logic [2:0] REG_LAT_BINS = 3'd0;
    localparam logic [2:0] REG_LON_BINS = 3'd1;
    localparam logic [2:0] REG_LAT_SHIFT = 3'd2;
    localparam logic [2:0] REG_LON_SHIFT = 3'd3;
    localparam logic [2:0] REG_NOISE_THR = 3'd4;

    // operations
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct {
        logic [14:0] idx;
        logic [14:0] amp;
        logic [15:0] hits;
        logic        filled;
        logic        oor;
    } t_bin_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;

    geo_grid_bin_accumulator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // grid model state
    logic [7:0]         lat_bins_r;
    logic [8:0]         lon_bins_r;
    logic signed [13:0] lat_shift_r;
    logic signed [15:0] lon_shift_r;
    logic signed [14:0] noise_thr_r;
    logic signed [15:0] amp_store [GRID_DEPTH];
    logic [15:0]        hit_store [GRID_DEPTH];
    bit                 filled_store [GRID_DEPTH];
    int                 written_bins[$];

    t_bin_result pending_bins[$];

    int  errors = 0;
    int  n_adds = 0, n_reads = 0, n_oor = 0, n_results = 0;
    bit  idle_en = 1'b1;
    bit  hold_req = 1'b0;
    int  quiet_cycles = 0;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Grid model
    // ------------------------------------------------------------------
    function automatic longint floor_quot(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q = q - 1;
        return q;
    endfunction

    function automatic int rows_in_use();
        int r;
        r = (lat_bins_r == 0) ? 1 : int'(lat_bins_r);
        return (r > ROWS_MAX) ? ROWS_MAX : r;
    endfunction

    function automatic int cols_in_use();
        int c;
        c = (lon_bins_r == 0) ? 1 : int'(lon_bins_r);
        return (c > COLS_MAX) ? COLS_MAX : c;
    endfunction

    function automatic void apply_register(logic [2:0] idx, logic [15:0] val);
        case (idx)
            REG_LAT_BINS:  lat_bins_r  = val[7:0];
            REG_LON_BINS:  lon_bins_r  = val[8:0];
            REG_LAT_SHIFT: lat_shift_r = val[13:0];
            REG_LON_SHIFT: lon_shift_r = val[15:0];
            REG_NOISE_THR: noise_thr_r = val[14:0];
            default: ;
        endcase
    endfunction

    // Work out the bin update for one accepted transaction.
    function automatic t_bin_result bin_update(logic op, logic signed [13:0] lat,
                                               logic [14:0] lon, logic signed [14:0] e,
                                               logic [14:0] ridx);
        t_bin_result r;
        int     rows, cols, idx;
        longint row, col, a, h, num;
        rows = rows_in_use();
        cols = cols_in_use();
        r = '{default: '0};
        if (op == OP_READ) begin
            n_reads++;
            r.idx = ridx;
            if (int'(ridx) >= rows * cols) begin
                r.oor = 1'b1;
                n_oor++;
                return r;
            end
            idx = int'(ridx);
        end else begin
            n_adds++;
            row = floor_quot((5760 - longint'(lat) - longint'(lat_shift_r)) * rows, 11520);
            col = floor_quot((longint'(lon) + longint'(lon_shift_r)) * cols, 23040);
            if (row < 0 || row >= rows || col < 0 || col >= cols) begin
                r.oor = 1'b1;
                n_oor++;
                return r;
            end
            idx = int'(row) * cols + int'(col);
            a = filled_store[idx] ? longint'(amp_store[idx]) : 0;
            h = longint'(hit_store[idx]);
            if (e < noise_thr_r) begin
                // cap sample
                if (!filled_store[idx]) begin
                    a = e;
                end else if (a > -longint'(e)) begin
                    a = -longint'(e);
                    if (h < 65535) h++;
                end else if (a < e) begin
                    a = e;
                end
            end else begin
                // running average, truncated toward zero
                num = h * a + longint'(e);
                a = num / (h + 1);
                if (h < 65535) h++;
                if (a < e) a = e;
            end
            if (!filled_store[idx]) written_bins.push_back(idx);
            amp_store[idx]    = a[15:0];
            hit_store[idx]    = h[15:0];
            filled_store[idx] = 1'b1;
            r.idx = idx[14:0];
        end
        if (filled_store[idx]) begin
            r.amp    = amp_store[idx][14:0];
            r.filled = 1'b1;
        end
        r.hits = hit_store[idx];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic write_register(logic [2:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_register(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_item(logic op, logic [13:0] lat, logic [14:0] lon,
                             logic [14:0] e, logic [14:0] ridx);
        // drop valid for a random burst; valid stays high between back-to-back items
        if (idle_en && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {5'b0, ridx, e, lon, lat};
        do @(posedge i_clk); while (!o_s_tready);
        pending_bins.push_back(bin_update(op, lat, lon, e, ridx));
    endtask

    task automatic stop_sending();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold until every expected result has come, then let the block settle.
    task automatic wait_drained();
        stop_sending();
        while (pending_bins.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_grid(int lat_b, int lon_b, int lat_s, int lon_s, int thr);
        write_register(REG_LAT_BINS,  16'(lat_b));
        write_register(REG_LON_BINS,  16'(lon_b));
        write_register(REG_LAT_SHIFT, 16'(lat_s));
        write_register(REG_LON_SHIFT, 16'(lon_s));
        write_register(REG_NOISE_THR, 16'(thr));
    endtask

    // Pick a read index: a bin that has been written, or one past the grid.
    function automatic logic [14:0] pick_read_index();
        int lim, k;
        lim = rows_in_use() * cols_in_use();
        if (lim < GRID_DEPTH && ($urandom_range(0, 3) == 0 || written_bins.size() == 0))
            return 15'($urandom_range(lim, GRID_DEPTH - 1));
        for (int t = 0; t < 8 && written_bins.size() != 0; t++) begin
            k = written_bins[$urandom_range(0, written_bins.size() - 1)];
            if (k < lim) return 15'(k);
        end
        return 15'h7FFF;  // flagged as no candidate
    endfunction

    task automatic send_random_item();
        logic [13:0] lat;
        logic [14:0] lon, e, ridx;
        int          sel;
        sel  = $urandom_range(0, 99);
        ridx = 15'($urandom);
        if (sel < 20) begin
            ridx = pick_read_index();
            if (ridx != 15'h7FFF || rows_in_use() * cols_in_use() < GRID_DEPTH) begin
                send_item(OP_READ, 14'($urandom), 15'($urandom), 15'($urandom), ridx);
                return;
            end
        end
        // mostly on-grid samples; a few with any field value at all
        if (sel > 94) begin
            lat = 14'($urandom);
            lon = 15'($urandom);
        end else begin
            lat = 14'($signed($urandom_range(0, 11520)) - 5760);
            lon = 15'($urandom_range(0, 23040));
        end
        case ($urandom_range(0, 3))
            0:       e = 15'(int'(noise_thr_r) - 1 - $urandom_range(0, 300));
            1:       e = 15'(int'(noise_thr_r) + $urandom_range(0, 300));
            default: e = 15'($urandom);
        endcase
        send_item(OP_ADD, lat, lon, e, ridx);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, or a long hold counted here on request
    // ------------------------------------------------------------------
    initial begin
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Result checker and watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_bin_result exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n_results++;
            if (pending_bins.size() == 0) begin
                $error("result with no transaction pending: %h", o_m_tdata);
                errors++;
            end else begin
                exp_r = pending_bins.pop_front();
                if (o_m_tdata[14:0] !== exp_r.idx) begin
                    $error("bin_index exp %0d got %0d", exp_r.idx, o_m_tdata[14:0]);
                    errors++;
                end
                if (o_m_tdata[29:15] !== exp_r.amp) begin
                    $error("bin_amplitude exp %0d got %0d",
                           $signed(exp_r.amp), $signed(o_m_tdata[29:15]));
                    errors++;
                end
                if (o_m_tdata[45:30] !== exp_r.hits) begin
                    $error("bin_hits exp %0d got %0d", exp_r.hits, o_m_tdata[45:30]);
                    errors++;
                end
                if (o_m_tdata[46] !== exp_r.filled) begin
                    $error("bin_filled exp %0b got %0b", exp_r.filled, o_m_tdata[46]);
                    errors++;
                end
                if (o_m_tdata[47] !== exp_r.oor) begin
                    $error("out_of_range exp %0b got %0b", exp_r.oor, o_m_tdata[47]);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Extremes of every field, three cap branches, averaging and both range flags.
    task automatic test_directed();
        send_item(OP_ADD, 14'sd5760, 15'd0, 15'sd100, 15'd0);        // top-left, average
        send_item(OP_ADD, 14'sd5760, 15'd0, 15'sd300, 15'd0);        // average, energy wins
        send_item(OP_ADD, 14'sd5760, 15'd0, -15'sd200, 15'd0);       // cap, amp above -e
        send_item(OP_ADD, 14'sd5760, 15'd0, 15'h4000, 15'd0);        // cap at energy minimum
        send_item(OP_ADD, 14'sd5760, 15'd0, -15'sd50, 15'd0);        // cap, amp above -e
        send_item(OP_ADD, -14'sd5760, 15'd0, 15'h4000, 15'd0);       // lat at span: off grid
        send_item(OP_ADD, -14'sd5759, 15'd23039, -15'sd1000, 15'd0); // cap on unfilled bin
        send_item(OP_ADD, -14'sd5759, 15'd23039, 15'sd16383, 15'd0);
        send_item(OP_ADD, 14'sd0, 15'd23040, 15'sd0, 15'd0);         // lon at span: off grid
        send_item(OP_ADD, 14'sd8191, 15'd32767, 15'sd1, 15'h7FFF);   // field maxima
        send_item(OP_ADD, 14'h2000, 15'd11520, -15'sd26, 15'd0);     // lat minimum, e at threshold
        send_item(OP_ADD, 14'sd1, 15'd11520, -15'sd27, 15'd0);       // just below threshold
        send_item(OP_READ, 14'sd0, 15'd0, 15'sd0, 15'd0);            // filled bin read
        send_item(OP_READ, 14'sd0, 15'd0, 15'sd0, 15'd32767);        // last bin, written
        for (int k = 0; k < 4; k++)
            send_item(OP_ADD, 14'sd5700, 15'd100, 15'($urandom), 15'd0);
        wait_drained();
        write_register(REG_LAT_BINS, 16'd2);
        write_register(REG_LON_BINS, 16'd2);
        send_item(OP_READ, 14'sd0, 15'd0, 15'sd0, 15'd4);            // read past grid
        send_item(OP_READ, 14'sd0, 15'd0, 15'sd0, 15'd32767);
        send_item(OP_READ, 14'sd0, 15'd0, 15'sd0, 15'd0);
        wait_drained();
    endtask

    task automatic test_random_grid(int n_items);
        for (int k = 0; k < n_items; k++) send_random_item();
        wait_drained();
    endtask

    // Stall the result side long enough to back the block up.
    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int k = 0; k < 20; k++) send_random_item();
        wait_drained();
    endtask

    task automatic test_grid_settings();
        set_grid(1, 1, 0, 0, 0);
        test_random_grid(80);
        set_grid(128, 256, 5760, 23040, -16384);
        test_random_grid(80);
        set_grid(128, 256, -5760, -23040, -26);
        test_random_grid(80);
        set_grid(3, 5, $urandom_range(0, 400), $urandom_range(0, 800), -26);
        test_random_grid(120);
        set_grid(0, 0, 0, 0, -1);      // zero acts as one
        test_random_grid(40);
        set_grid(255, 511, 0, 0, -300); // saturate to the maxima
        test_random_grid(60);
        set_grid(6, 12, -128, 64, -26);
        test_random_grid(120);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_LAT_BINS;
        i_cfg_data  <= '0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= OP_ADD;
        lat_bins_r  = 8'd128;
        lon_bins_r  = 9'd256;
        lat_shift_r = '0;
        lon_shift_r = '0;
        noise_thr_r = -15'sd26;
        for (int k = 0; k < GRID_DEPTH; k++) begin
            amp_store[k]    = '0;
            hit_store[k]    = '0;
            filled_store[k] = 1'b0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        set_grid(128, 256, 0, 0, -26);
        test_random_grid(60);
        test_backpressure();
        test_grid_settings();
        // last stretch with both sides always ready
        idle_en = 1'b0;
        set_grid(4, 4, 0, 0, -26);
        test_random_grid(80);

        $display("covered %0d samples and %0d reads, %0d outside the grid, %0d results",
                 n_adds, n_reads, n_oor, n_results);
        $display("grid settings from 1x1 to saturated 128x256, shifts and thresholds at extremes");
        if (errors == 0 && pending_bins.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/ggba_pkg.sv
sv/ggba_ram.sv
sv/ggba_div.sv
sv/ggba_dpath.sv
sv/ggba_ctrl.sv
sv/geo_grid_bin_accumulator_unit.sv
sv/ggba_chk.sv
tb/sv/tb.sv
